// ===== src/dtnm_pkg.sv =====
// Shared widths, types and constants for the dual tree neighbor map.
package dtnm_pkg;

   localparam int unsigned CNT_W   = 11;
   localparam int unsigned RANK_W  = 10;
   localparam int unsigned HALF_W  = 10;
   localparam int unsigned LAYER_W = 4;

   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [RANK_W-1:0]  rank_type;
   typedef logic [HALF_W-1:0]  half_type;
   typedef logic [LAYER_W-1:0] layer_type;

   localparam cnt_type MIN_PROCS   = 11'd2;
   localparam cnt_type MAX_PROCS   = 11'd1024;
   localparam cnt_type RESET_COUNT = 11'd2;
   // Absent neighbor: -1 in 11 bits
   localparam cnt_type NONE_RANK   = 11'h7FF;

endpackage

// ===== src/dtnm_if.sv =====
// Channel interfaces: rank requests, neighbor map responses, count register writes.
interface dtnm_req_if;
   logic                valid;
   logic                ready;
   dtnm_pkg::rank_type  rank;

   modport source (output valid, output rank, input ready);
   modport sink   (input valid, input rank, output ready);
endinterface

interface dtnm_rsp_if;
   logic                valid;
   logic                ready;
   dtnm_pkg::cnt_type   node_index;
   dtnm_pkg::cnt_type   parent_rank;
   dtnm_pkg::cnt_type   left_rank;
   dtnm_pkg::cnt_type   right_rank;
   dtnm_pkg::layer_type node_layer;
   dtnm_pkg::layer_type tree_height;
   dtnm_pkg::cnt_type   dual_rank;

   modport source (output valid, output node_index, output parent_rank, output left_rank,
                   output right_rank, output node_layer, output tree_height,
                   output dual_rank, input ready);
   modport sink   (input valid, input node_index, input parent_rank, input left_rank,
                   input right_rank, input node_layer, input tree_height,
                   input dual_rank, output ready);
endinterface

interface dtnm_csr_if;
   logic                valid;
   logic                ready;
   dtnm_pkg::cnt_type   data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/dual_tree_neighbor_map.sv =====
// Top level: maps a rank onto its place in one of two in-order binary trees.
// A word accepted on req_bus is held in the input register and then in the result
// register, from which it is offered on rsp_bus.
// Throughput: one word per cycle while rsp_bus is ready; an input register
// and a result register with one pass of mapping logic between them.
// The count register feeds a set of registered derived tree sizes.
// Reset (synchronous, active high) empties both stages and sets the count to 2.
module dual_tree_neighbor_map (
   input  logic         clock,
   input  logic         reset,
   dtnm_req_if.sink     req_bus,
   dtnm_rsp_if.source   rsp_bus,
   dtnm_csr_if.sink     csr_bus
);

   function automatic dtnm_pkg::cnt_type unskip(input dtnm_pkg::cnt_type n,
                                                 input dtnm_pkg::cnt_type ov);
      dtnm_pkg::cnt_type d;
      d = n + dtnm_pkg::CNT_W'(1) - ov;
      if ((n + dtnm_pkg::CNT_W'(1)) > ov) return n - (d >> 1);
      return n;
   endfunction

   function automatic dtnm_pkg::layer_type trailing_ones(input dtnm_pkg::cnt_type v);
      dtnm_pkg::layer_type n;
      logic                done;
      n    = '0;
      done = 1'b0;
      for (int i = 0; i < dtnm_pkg::CNT_W; i++) begin
         if (!done && v[i]) n = n + dtnm_pkg::LAYER_W'(1);
         else done = 1'b1;
      end
      return n;
   endfunction

   // ---------------- count register and derived tree sizes ----------------
   dtnm_pkg::cnt_type   count_ff;
   dtnm_pkg::cnt_type   p_in,     p_ff;
   dtnm_pkg::half_type  hc_in,    hc_ff;
   dtnm_pkg::layer_type th_in,    th_ff;
   dtnm_pkg::cnt_type   full_in,  full_ff;
   dtnm_pkg::cnt_type   ov_l_in,  ov_l_ff;
   dtnm_pkg::cnt_type   ov_r_in,  ov_r_ff;
   dtnm_pkg::cnt_type   dual_l_in, dual_l_ff;
   dtnm_pkg::cnt_type   dual_r_in, dual_r_ff;
   dtnm_pkg::cnt_type   hc_w, hf_w, base_w;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= dtnm_pkg::RESET_COUNT;
      end else if (csr_bus.valid) begin
         count_ff <= csr_bus.data;
      end
   end

   always_comb begin
      if (count_ff < dtnm_pkg::MIN_PROCS)      p_in = dtnm_pkg::MIN_PROCS;
      else if (count_ff > dtnm_pkg::MAX_PROCS) p_in = dtnm_pkg::MAX_PROCS;
      else                                     p_in = count_ff;
      hc_w  = (p_in + dtnm_pkg::CNT_W'(1)) >> 1;
      hf_w  = p_in >> 1;
      hc_in = hc_w[dtnm_pkg::HALF_W-1:0];
      th_in = '0;
      for (int i = 0; i < dtnm_pkg::HALF_W; i++) begin
         if (hc_in[i]) th_in = dtnm_pkg::LAYER_W'(i);
      end
      full_in   = (dtnm_pkg::CNT_W'(1) << (th_in + dtnm_pkg::LAYER_W'(1)))
                  - dtnm_pkg::CNT_W'(1);
      base_w    = (dtnm_pkg::CNT_W'(1) << th_in) - dtnm_pkg::CNT_W'(1);
      ov_l_in   = (hc_w - base_w) << 1;
      ov_r_in   = (hf_w - base_w) << 1;
      // Root of the other tree, seen from a root of each tree
      dual_l_in = unskip(base_w, ov_r_in) + hc_w;
      dual_r_in = unskip(base_w, ov_l_in);
   end

   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      hc_ff     <= hc_in;
      th_ff     <= th_in;
      full_ff   <= full_in;
      ov_l_ff   <= ov_l_in;
      ov_r_ff   <= ov_r_in;
      dual_l_ff <= dual_l_in;
      dual_r_ff <= dual_r_in;
   end

   // ---------------- handshake and stage control ----------------
   logic               s1_valid_in, s1_valid_ff;
   dtnm_pkg::rank_type s1_rank_ff;
   logic               rsp_valid_in, rsp_valid_ff;
   logic               req_fire, s1_adv;

   assign s1_adv        = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire)    s1_valid_in = 1'b1;
      else if (s1_adv) s1_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv)             rsp_valid_in = 1'b1;
      else if (rsp_bus.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) s1_rank_ff <= req_bus.rank;
   end

   // ---------------- mapping ----------------
   logic                in_range, second, par_ok, lft_ok, rgt_ok;
   dtnm_pkg::cnt_type   rank_w, off, ov, r, s, node, h;
   dtnm_pkg::cnt_type   par_raw, lft_raw, rgt_raw, par_v, lft_v, rgt_v;
   dtnm_pkg::layer_type layer;
   dtnm_pkg::cnt_type   node_out, par_out, lft_out, rgt_out, dual_out;
   dtnm_pkg::layer_type layer_out;

   always_comb begin
      rank_w   = {1'b0, s1_rank_ff};
      in_range = rank_w < p_ff;
      second   = rank_w >= {1'b0, hc_ff};
      off      = second ? {1'b0, hc_ff} : '0;
      ov       = second ? ov_r_ff : ov_l_ff;
      r        = rank_w - off;
      // Skip the missing positions of the last layer
      s        = ((r + dtnm_pkg::CNT_W'(1)) > ov) ? (r + dtnm_pkg::CNT_W'(1) - ov) : '0;
      node     = r + s;
      layer    = trailing_ones(node);

      par_ok   = layer < th_ff;
      par_raw  = ((node >> (layer + dtnm_pkg::LAYER_W'(2))) << (layer + dtnm_pkg::LAYER_W'(2)))
                 | ((dtnm_pkg::CNT_W'(1) << (layer + dtnm_pkg::LAYER_W'(1)))
                    - dtnm_pkg::CNT_W'(1));
      h        = dtnm_pkg::CNT_W'(1) << (layer - dtnm_pkg::LAYER_W'(1));
      lft_raw  = node - h;
      rgt_raw  = node + h;
      lft_ok   = (layer != '0) && !(!lft_raw[0] && (lft_raw >= ov));
      rgt_ok   = (layer != '0) && !(!rgt_raw[0] && (rgt_raw >= ov));

      par_v    = unskip(par_raw, ov) + off;
      lft_v    = unskip(lft_raw, ov) + off;
      rgt_v    = unskip(rgt_raw, ov) + off;
      lft_ok   = lft_ok && (lft_v < p_ff);
      rgt_ok   = rgt_ok && (rgt_v < p_ff);

      if (in_range) begin
         node_out  = second ? (node + full_ff) : node;
         layer_out = layer;
         par_out   = par_ok ? par_v : dtnm_pkg::NONE_RANK;
         lft_out   = lft_ok ? lft_v : dtnm_pkg::NONE_RANK;
         rgt_out   = rgt_ok ? rgt_v : dtnm_pkg::NONE_RANK;
         dual_out  = par_ok ? dtnm_pkg::NONE_RANK : (second ? dual_r_ff : dual_l_ff);
      end else begin
         node_out  = '0;
         layer_out = '0;
         par_out   = dtnm_pkg::NONE_RANK;
         lft_out   = dtnm_pkg::NONE_RANK;
         rgt_out   = dtnm_pkg::NONE_RANK;
         dual_out  = dtnm_pkg::NONE_RANK;
      end
   end

   // ---------------- result register ----------------
   dtnm_pkg::cnt_type   node_ff, par_ff, lft_ff, rgt_ff, dual_ff;
   dtnm_pkg::layer_type layer_ff, height_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         node_ff   <= node_out;
         par_ff    <= par_out;
         lft_ff    <= lft_out;
         rgt_ff    <= rgt_out;
         dual_ff   <= dual_out;
         layer_ff  <= layer_out;
         height_ff <= th_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.node_index  = node_ff;
   assign rsp_bus.parent_rank = par_ff;
   assign rsp_bus.left_rank   = lft_ff;
   assign rsp_bus.right_rank  = rgt_ff;
   assign rsp_bus.node_layer  = layer_ff;
   assign rsp_bus.tree_height = height_ff;
   assign rsp_bus.dual_rank   = dual_ff;

`ifndef SYNTHESIS
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_rank_ff))
      else $error("input stage lost or changed a stalled word");

   a_s1_fill: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted word missing from input stage");

   a_dual_root: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (dual_ff != dtnm_pkg::NONE_RANK) |-> par_ff == dtnm_pkg::NONE_RANK)
      else $error("dual rank given for a non-root");

   a_parent_layer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (par_ff != dtnm_pkg::NONE_RANK) |-> layer_ff < height_ff)
      else $error("parent given at or above tree height");

   a_child_layer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ((lft_ff != dtnm_pkg::NONE_RANK) || (rgt_ff != dtnm_pkg::NONE_RANK))
      |-> layer_ff != '0)
      else $error("child given for a leaf");
`endif

endmodule
